FILE: rtl/esds_pkg.sv
// ----------------------------------------------------------------------------
// esds_pkg
// Shared widths, constants and types for the edge seam difference statistics
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package esds_pkg;

  // Channels per pixel and bits per channel
  localparam int CHANNELS = 4;
  localparam int CH_LOG   = 2;
  localparam int PIX_W    = 8;

  // Width of one pair's four-channel difference sum (4 * 255 < 2**10)
  localparam int SUM_W = PIX_W + CH_LOG;

  // Result field widths
  localparam int PAIR_W  = 13;
  localparam int TOTAL_W = 22;
  localparam int MATCH_W = 13;
  localparam int MEAN_W  = 16;

  // Mean in Q8.8 = total * 256 / (pairs * 4) = (total << 6) / pairs
  localparam int Q_FRAC     = 8;
  localparam int MEAN_SHIFT = Q_FRAC - CH_LOG;
  // Dividend bits that the divider shifts in one per step
  localparam int LOW_W      = MEAN_W - MEAN_SHIFT;

  // Default pair limit per edge
  localparam int MAX_EDGE_PIXELS_DEF = 4096;

  // Divider sequencer states
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Divider status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // What the merge stage found over the lanes for one pair
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] max;
    logic             all_equal;
  } merge_result_t;

endpackage

`default_nettype wire

FILE: rtl/esds_lane.sv
// ----------------------------------------------------------------------------
// esds_lane
// One channel lane: absolute difference of two unsigned channel values.
// ----------------------------------------------------------------------------
`default_nettype none

module esds_lane (
  input  wire logic [esds_pkg::PIX_W-1:0] first_ch,
  input  wire logic [esds_pkg::PIX_W-1:0] second_ch,
  output logic      [esds_pkg::PIX_W-1:0] diff
);

  // Subtract the smaller value from the larger
  always_comb begin
    if (first_ch > second_ch) begin
      diff = first_ch - second_ch;
    end else begin
      diff = second_ch - first_ch;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/esds_merge.sv
// ----------------------------------------------------------------------------
// esds_merge
// Combine the lane differences of one pair: sum, largest value and the
// all-channels-equal flag.
// ----------------------------------------------------------------------------
`default_nettype none

module esds_merge (
  input  wire logic [esds_pkg::CHANNELS-1:0][esds_pkg::PIX_W-1:0] diffs,
  output esds_pkg::merge_result_t                                 result
);

  logic [esds_pkg::SUM_W-1:0] sum;
  logic [esds_pkg::PIX_W-1:0] max;
  logic                       any_diff;

  // Add, compare and OR across the four lanes
  always_comb begin
    sum      = '0;
    max      = '0;
    any_diff = 1'b0;
    for (int i = 0; i < esds_pkg::CHANNELS; i++) begin
      sum      = sum + esds_pkg::SUM_W'(diffs[i]);
      any_diff = any_diff | (|diffs[i]);
      if (diffs[i] > max) begin
        max = diffs[i];
      end
    end
  end

  assign result.sum       = sum;
  assign result.max       = max;
  assign result.all_equal = ~any_diff;

endmodule

`default_nettype wire

FILE: rtl/esds_div.sv
// ----------------------------------------------------------------------------
// esds_div
// Restoring divider for the mean: (total << 6) / pairs, one quotient bit per
// cycle. The quotient is known to fit in 16 bits, so the upper dividend bits
// seed the remainder and only 16 steps are run.
// ----------------------------------------------------------------------------
`default_nettype none

module esds_div #(
  parameter int CNT_W = 13
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      start,
  input  wire logic [CNT_W+esds_pkg::LOW_W-1:0]          dividend,
  input  wire logic [CNT_W-1:0]                          divisor,
  output esds_pkg::div_status_t                          status,
  output logic      [esds_pkg::MEAN_W-1:0]               quotient
);

  localparam int TOT_W  = CNT_W + esds_pkg::LOW_W;
  localparam int STEP_W = $clog2(esds_pkg::MEAN_W);

  esds_pkg::div_state_t state, state_next;

  logic [CNT_W-1:0]            rem;
  logic [CNT_W-1:0]            rem_next;
  logic [esds_pkg::MEAN_W-1:0] quo;
  logic [esds_pkg::MEAN_W-1:0] quo_next;
  logic [CNT_W-1:0]            den;
  logic [STEP_W-1:0]           step;
  logic [CNT_W:0]              trial;
  logic [CNT_W:0]              trial_sub;
  logic                        fits;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esds_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      esds_pkg::DIV_IDLE: begin
        if (start) begin
          state_next = esds_pkg::DIV_RUN;
        end
      end
      esds_pkg::DIV_RUN: begin
        if (step == STEP_W'(esds_pkg::MEAN_W - 1)) begin
          state_next = esds_pkg::DIV_DONE;
        end
      end
      esds_pkg::DIV_DONE: begin
        state_next = esds_pkg::DIV_IDLE;
      end
      default: begin
        state_next = esds_pkg::DIV_IDLE;
      end
    endcase
  end

  // One trial subtraction per step
  always_comb begin
    trial     = {rem, quo[esds_pkg::MEAN_W-1]};
    trial_sub = trial - {1'b0, den};
    fits      = (trial >= {1'b0, den});
    rem_next  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    quo_next  = {quo[esds_pkg::MEAN_W-2:0], fits};
  end

  // Load operands on start, shift while running
  always_ff @(posedge clk) begin
    if (state == esds_pkg::DIV_IDLE && start) begin
      rem  <= dividend[TOT_W-1:esds_pkg::LOW_W];
      quo  <= {dividend[esds_pkg::LOW_W-1:0], {esds_pkg::MEAN_SHIFT{1'b0}}};
      den  <= divisor;
      step <= '0;
    end else if (state == esds_pkg::DIV_RUN) begin
      rem  <= rem_next;
      quo  <= quo_next;
      step <= step + 1'b1;
    end
  end

  assign status.busy = (state == esds_pkg::DIV_RUN);
  assign status.done = (state == esds_pkg::DIV_DONE);
  assign quotient    = quo;

`ifndef SYNTHESIS
  // The partial remainder stays below the divisor throughout the run
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == esds_pkg::DIV_RUN |-> rem < den)
    else $error("divider remainder not below divisor");

  // Done lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    status.done |=> !status.done)
    else $error("divider done held longer than one cycle");

  // A run takes one step per quotient bit and then signals done
  a_run_length: assert property (@(posedge clk) disable iff (rst)
    $rose(status.busy) |-> ##(esds_pkg::MEAN_W) status.done)
    else $error("divider run length wrong");
`endif

endmodule

`default_nettype wire

FILE: rtl/edge_seam_difference_stats_top.sv
// ----------------------------------------------------------------------------
// edge_seam_difference_stats_top
// Seam statistics over RGBA pixel pairs taken from two opposing texture edges.
//
// Input channel (in_valid / in_stall): one pixel pair per item. Four lanes
// form the channel absolute differences and a merge stage adds them, takes
// their maximum and flags a full match; the accumulators update in the cycle
// of acceptance, so pairs without last_pair are taken one per cycle.
// Pairs beyond MAX_EDGE_PIXELS are dropped from the statistics.
// Output channel (out_valid / out_stall): one result item per edge, issued
// after the pair marked last_pair. The mean comes from a bit-serial divider;
// out_valid is registered from the divider's done state.
// A pair marked last_pair is stalled while the divider runs or finishes or a
// result waits in the output register; other pairs keep flowing into the
// cleared accumulators for the next edge. A stalled result holds its fields.
// Reset clears the accumulators, the divider and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_seam_difference_stats_top #(
  parameter int MAX_EDGE_PIXELS = esds_pkg::MAX_EDGE_PIXELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [esds_pkg::PIX_W-1:0]     first_red,
  input  wire logic [esds_pkg::PIX_W-1:0]     first_green,
  input  wire logic [esds_pkg::PIX_W-1:0]     first_blue,
  input  wire logic [esds_pkg::PIX_W-1:0]     first_alpha,
  input  wire logic [esds_pkg::PIX_W-1:0]     second_red,
  input  wire logic [esds_pkg::PIX_W-1:0]     second_green,
  input  wire logic [esds_pkg::PIX_W-1:0]     second_blue,
  input  wire logic [esds_pkg::PIX_W-1:0]     second_alpha,
  input  wire logic                           last_pair,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [esds_pkg::PAIR_W-1:0]    pairs_compared,
  output logic      [esds_pkg::TOTAL_W-1:0]   difference_total,
  output logic      [esds_pkg::PIX_W-1:0]     largest_channel_difference,
  output logic      [esds_pkg::MATCH_W-1:0]   matching_pairs,
  output logic      [esds_pkg::MEAN_W-1:0]    mean_difference_q8_8
);

  localparam int CNT_W = $clog2(MAX_EDGE_PIXELS + 1);
  localparam int TOT_W = CNT_W + esds_pkg::SUM_W;

  logic [esds_pkg::CHANNELS-1:0][esds_pkg::PIX_W-1:0] first_px;
  logic [esds_pkg::CHANNELS-1:0][esds_pkg::PIX_W-1:0] second_px;
  logic [esds_pkg::CHANNELS-1:0][esds_pkg::PIX_W-1:0] diffs;
  esds_pkg::merge_result_t                            pair_stats;
  esds_pkg::div_status_t                              div_status;
  logic [esds_pkg::MEAN_W-1:0]                        div_quotient;

  logic [CNT_W-1:0]          pair_counter;
  logic [CNT_W-1:0]          pair_counter_next;
  logic [TOT_W-1:0]          running_total;
  logic [TOT_W-1:0]          running_total_next;
  logic [esds_pkg::PIX_W-1:0] running_maximum;
  logic [esds_pkg::PIX_W-1:0] running_maximum_next;
  logic [CNT_W-1:0]          match_counter;
  logic [CNT_W-1:0]          match_counter_next;

  logic in_accept;
  logic out_accept;
  logic has_room;
  logic finish;

  assign first_px  = {first_alpha, first_blue, first_green, first_red};
  assign second_px = {second_alpha, second_blue, second_green, second_red};

  // Channel lanes
  for (genvar i = 0; i < esds_pkg::CHANNELS; i++) begin : g_lane
    esds_lane u_lane (
      .first_ch  (first_px[i]),
      .second_ch (second_px[i]),
      .diff      (diffs[i])
    );
  end

  // Merge the lanes
  esds_merge u_merge (
    .diffs  (diffs),
    .result (pair_stats)
  );

  // Hold a closing pair while the divider or the output register is occupied
  assign in_stall   = last_pair & (div_status.busy | div_status.done | out_valid);
  assign in_accept  = in_valid & ~in_stall;
  assign out_accept = out_valid & ~out_stall;
  assign has_room   = (pair_counter < CNT_W'(MAX_EDGE_PIXELS));
  assign finish     = in_accept & last_pair;

  // Fold the pair into the accumulators
  always_comb begin
    pair_counter_next    = pair_counter;
    running_total_next   = running_total;
    running_maximum_next = running_maximum;
    match_counter_next   = match_counter;
    if (in_accept && has_room) begin
      pair_counter_next  = pair_counter + 1'b1;
      running_total_next = running_total + TOT_W'(pair_stats.sum);
      if (pair_stats.max > running_maximum) begin
        running_maximum_next = pair_stats.max;
      end
      if (pair_stats.all_equal) begin
        match_counter_next = match_counter + 1'b1;
      end
    end
  end

  // Update accumulators; clear them when an edge closes
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      pair_counter    <= '0;
      running_total   <= '0;
      running_maximum <= '0;
      match_counter   <= '0;
    end else begin
      pair_counter    <= pair_counter_next;
      running_total   <= running_total_next;
      running_maximum <= running_maximum_next;
      match_counter   <= match_counter_next;
    end
  end

  // Mean divider
  esds_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (finish),
    .dividend (running_total_next),
    .divisor  (pair_counter_next),
    .status   (div_status),
    .quotient (div_quotient)
  );

  // Capture the edge statistics when it closes
  always_ff @(posedge clk) begin
    if (finish) begin
      pairs_compared             <= esds_pkg::PAIR_W'(pair_counter_next);
      difference_total           <= esds_pkg::TOTAL_W'(running_total_next);
      largest_channel_difference <= running_maximum_next;
      matching_pairs             <= esds_pkg::MATCH_W'(match_counter_next);
    end
    if (div_status.done) begin
      mean_difference_q8_8 <= div_quotient;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_status.done) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // A finished division always lands in the output register
  a_done_to_valid: assert property (@(posedge clk) disable iff (rst)
    div_status.done |=> out_valid)
    else $error("divider result not presented");

  // A taken result is not followed at once by another
  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    out_accept |=> !out_valid)
    else $error("result issued twice");

  // An edge never closes while a result is pending
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    finish |-> !out_valid && !div_status.busy && !div_status.done)
    else $error("edge closed while result pending");

  // The pair count never passes the limit, nor the match count the pair count
  a_pair_limit: assert property (@(posedge clk) disable iff (rst)
    pair_counter <= CNT_W'(MAX_EDGE_PIXELS) && match_counter <= pair_counter)
    else $error("pair counters out of range");
`endif

endmodule

`default_nettype wire

FILE: test/edge_seam_difference_stats_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_seam_difference_stats_top_test
// Drives RGBA pixel pairs into the seam statistics block edge by edge and
// checks every per-edge result against a cycle-free model of the counts, the
// total, the peak channel difference, the match count and the Q8.8 mean.
// Both handshakes idle and stall at random; one long receiver hold-off fills
// the block so that it stalls its input.
// ----------------------------------------------------------------------------

// One pixel pair; channel index 0 is red, 1 green, 2 blue, 3 alpha
typedef struct packed {
  logic [esds_pkg::CHANNELS-1:0][esds_pkg::PIX_W-1:0] first_px;
  logic [esds_pkg::CHANNELS-1:0][esds_pkg::PIX_W-1:0] second_px;
  logic                                                last;
} pixel_pair_t;

// Statistics reported for one edge
typedef struct packed {
  logic [esds_pkg::PAIR_W-1:0]  pairs;
  logic [esds_pkg::TOTAL_W-1:0] total;
  logic [esds_pkg::PIX_W-1:0]   peak;
  logic [esds_pkg::MATCH_W-1:0] match_count;
  logic [esds_pkg::MEAN_W-1:0]  mean;
} seam_stats_t;

class seam_scoreboard;
  localparam int unsigned EDGE_LIMIT = esds_pkg::MAX_EDGE_PIXELS_DEF;
  localparam int unsigned MEAN_SCALE = (1 << esds_pkg::Q_FRAC) / esds_pkg::CHANNELS;

  int unsigned edge_pairs;
  int unsigned edge_total;
  int unsigned edge_peak;
  int unsigned edge_matches;
  seam_stats_t pending_edges[$];
  int failures;
  int results_checked;

  function new();
    edge_pairs = 0;
    edge_total = 0;
    edge_peak = 0;
    edge_matches = 0;
    failures = 0;
    results_checked = 0;
  endfunction

  // Accumulate one accepted pair; close the edge on last
  function void note_pair(pixel_pair_t p);
    int unsigned gap;
    bit all_same;
    longint unsigned mean;
    seam_stats_t stats;
    if (edge_pairs < EDGE_LIMIT) begin
      all_same = 1'b1;
      for (int c = 0; c < esds_pkg::CHANNELS; c++) begin
        gap = (p.first_px[c] > p.second_px[c]) ? p.first_px[c] - p.second_px[c]
                                                : p.second_px[c] - p.first_px[c];
        edge_total += gap;
        if (gap > edge_peak) edge_peak = gap;
        if (gap != 0) all_same = 1'b0;
      end
      edge_pairs++;
      if (all_same) edge_matches++;
    end
    if (p.last) begin
      mean = 0;
      if (edge_pairs != 0) mean = (longint'(edge_total) * MEAN_SCALE) / edge_pairs;
      stats.pairs       = edge_pairs[esds_pkg::PAIR_W-1:0];
      stats.total       = edge_total[esds_pkg::TOTAL_W-1:0];
      stats.peak        = edge_peak[esds_pkg::PIX_W-1:0];
      stats.match_count = edge_matches[esds_pkg::MATCH_W-1:0];
      stats.mean        = mean[esds_pkg::MEAN_W-1:0];
      pending_edges.push_back(stats);
      edge_pairs = 0;
      edge_total = 0;
      edge_peak = 0;
      edge_matches = 0;
    end
  endfunction

  function void compare_field(string label, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", label, want, got);
      failures++;
    end
  endfunction

  // Match one result item against the oldest closed edge
  function void check_result(seam_stats_t got);
    seam_stats_t want;
    if (pending_edges.size() == 0) begin
      $error("result item with no closed edge pending");
      failures++;
      return;
    end
    want = pending_edges.pop_front();
    results_checked++;
    compare_field("pairs_compared", want.pairs, got.pairs);
    compare_field("difference_total", want.total, got.total);
    compare_field("largest_channel_difference", want.peak, got.peak);
    compare_field("matching_pairs", want.match_count, got.match_count);
    compare_field("mean_difference_q8_8", want.mean, got.mean);
  endfunction
endclass

module edge_seam_difference_stats_top_test;

  localparam int QUIET_LIMIT    = 3000;
  localparam int HOLD_OFF       = 400;
  localparam int RANDOM_PAIRS   = 1450;
  localparam int DRAIN_CYCLES   = 40;
  localparam int IDLE_PERCENT   = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [esds_pkg::PIX_W-1:0] first_red = '0;
  logic [esds_pkg::PIX_W-1:0] first_green = '0;
  logic [esds_pkg::PIX_W-1:0] first_blue = '0;
  logic [esds_pkg::PIX_W-1:0] first_alpha = '0;
  logic [esds_pkg::PIX_W-1:0] second_red = '0;
  logic [esds_pkg::PIX_W-1:0] second_green = '0;
  logic [esds_pkg::PIX_W-1:0] second_blue = '0;
  logic [esds_pkg::PIX_W-1:0] second_alpha = '0;
  logic last_pair = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [esds_pkg::PAIR_W-1:0]  pairs_compared;
  logic [esds_pkg::TOTAL_W-1:0] difference_total;
  logic [esds_pkg::PIX_W-1:0]   largest_channel_difference;
  logic [esds_pkg::MATCH_W-1:0] matching_pairs;
  logic [esds_pkg::MEAN_W-1:0]  mean_difference_q8_8;

  seam_scoreboard board = new();
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  bit hold_off_req = 1'b0;
  int pairs_sent = 0;

  edge_seam_difference_stats_top dut (
    .clk                        (clk),
    .rst                        (rst),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .first_red                  (first_red),
    .first_green                (first_green),
    .first_blue                 (first_blue),
    .first_alpha                (first_alpha),
    .second_red                 (second_red),
    .second_green               (second_green),
    .second_blue                (second_blue),
    .second_alpha               (second_alpha),
    .last_pair                  (last_pair),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .pairs_compared             (pairs_compared),
    .difference_total           (difference_total),
    .largest_channel_difference (largest_channel_difference),
    .matching_pairs             (matching_pairs),
    .mean_difference_q8_8       (mean_difference_q8_8)
  );

  always #5 clk = ~clk;

  // Build a pair from two packed pixels: alpha, blue, green, red from high to low
  function automatic pixel_pair_t pair_of(logic [31:0] first_rgba, logic [31:0] second_rgba,
                                          bit last);
    pixel_pair_t p;
    p.first_px = first_rgba;
    p.second_px = second_rgba;
    p.last = last;
    return p;
  endfunction

  // Mix of matching, near, saturated and uniform pixel pairs
  function automatic pixel_pair_t random_pair(bit last);
    pixel_pair_t p;
    int mode;
    mode = $urandom_range(99);
    for (int c = 0; c < esds_pkg::CHANNELS; c++) begin
      p.first_px[c] = $urandom_range(255);
      if (mode < 25) begin
        p.second_px[c] = p.first_px[c];
      end else if (mode < 45) begin
        p.second_px[c] = p.first_px[c] + esds_pkg::PIX_W'($urandom_range(3));
      end else if (mode < 60) begin
        p.first_px[c] = $urandom_range(1) ? '1 : '0;
        p.second_px[c] = $urandom_range(1) ? '1 : '0;
      end else begin
        p.second_px[c] = $urandom_range(255);
      end
    end
    p.last = last;
    return p;
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_pair(pixel_pair_t p);
    if (!sender_calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    first_red    <= p.first_px[0];
    first_green  <= p.first_px[1];
    first_blue   <= p.first_px[2];
    first_alpha  <= p.first_px[3];
    second_red   <= p.second_px[0];
    second_green <= p.second_px[1];
    second_blue  <= p.second_px[2];
    second_alpha <= p.second_px[3];
    last_pair    <= p.last;
    do @(negedge clk); while (in_stall);
    board.note_pair(p);
    pairs_sent++;
    @(posedge clk);
  endtask

  // Random edges, mostly short, until the pair budget is spent
  task automatic send_random_edges(int budget);
    int len;
    int pick;
    int sent;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 10) len = 1;
      else if (pick < 80) len = $urandom_range(2, 16);
      else len = $urandom_range(17, 64);
      for (int i = 0; i < len; i++) send_pair(random_pair(i == len - 1));
      sent += len;
    end
  endtask

  // Receiver: random stalls, calm stretches and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_stall <= receiver_calm ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Check results mid-cycle, where every signal has settled
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_result('{pairs_compared, difference_total, largest_channel_difference,
                             matching_pairs, mean_difference_q8_8});
      end
    end
  end

  // End the run when no item moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-pair edges: all zero, full difference both ways
    send_pair(pair_of(32'h0000_0000, 32'h0000_0000, 1'b1));
    send_pair(pair_of(32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
    send_pair(pair_of(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
    // One channel at a time, a nonzero match, a one-step and a swapped pair
    send_pair(pair_of(32'h0000_00FF, 32'h0000_0000, 1'b0));
    send_pair(pair_of(32'h0000_FF00, 32'h0000_0000, 1'b0));
    send_pair(pair_of(32'h00FF_0000, 32'h0000_0000, 1'b0));
    send_pair(pair_of(32'hFF00_0000, 32'h0000_0000, 1'b0));
    send_pair(pair_of(32'h1234_5678, 32'h1234_5678, 1'b0));
    send_pair(pair_of(32'h8080_8080, 32'h7F7F_7F7F, 1'b0));
    send_pair(pair_of(32'h0102_0304, 32'h0403_0201, 1'b1));
    // Edge with nothing but matches
    send_pair(pair_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_pair(pair_of(32'hA5A5_5A5A, 32'hA5A5_5A5A, 1'b0));
    send_pair(pair_of(32'h5A5A_A5A5, 32'h5A5A_A5A5, 1'b1));
    // Mean that truncates: one unit over three pairs
    send_pair(pair_of(32'h0000_0001, 32'h0000_0000, 1'b0));
    send_pair(pair_of(32'h0000_0000, 32'h0000_0000, 1'b0));
    send_pair(pair_of(32'h0000_0000, 32'h0000_0000, 1'b1));

    // Random edges: hold off the receiver first, then a calm stretch
    hold_off_req = 1'b1;
    send_random_edges(RANDOM_PAIRS / 3);
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    send_random_edges(RANDOM_PAIRS / 5);
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    send_random_edges(RANDOM_PAIRS - RANDOM_PAIRS / 3 - RANDOM_PAIRS / 5);
    send_pair(random_pair(1'b1));
    in_valid <= 1'b0;

    // Drain
    while (board.pending_edges.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_edges.size() != 0) begin
      $error("%0d edge results never arrived", board.pending_edges.size());
      board.failures++;
    end

    $display("Sent %0d pixel pairs and checked %0d edge results: single-pair, all-match",
             pairs_sent, board.results_checked);
    $display("and truncating-mean edges, random stalls on both sides and one long hold-off.");
    if (board.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/esds_pkg.sv
rtl/esds_lane.sv
rtl/esds_merge.sv
rtl/esds_div.sv
rtl/edge_seam_difference_stats_top.sv
test/edge_seam_difference_stats_top_test.sv
